>>> rtl/dual_smooth_bump_eval_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual bump evaluator
// Concurrent assertion helpers, compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef DUAL_SMOOTH_BUMP_EVAL_ASSERT_SVH
`define DUAL_SMOOTH_BUMP_EVAL_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication, gated by reset
`define DSB_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication, gated by reset
`define DSB_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
// condition that must follow a reset cycle
`define DSB_ASSERT_RST(label, c) \
  label: assert property (@(posedge clk) rst |=> (c)) \
    else $error("assertion failed");
`else
`define DSB_ASSERT_IMPL(label, a, c)
`define DSB_ASSERT_NEXT(label, a, c)
`define DSB_ASSERT_RST(label, c)
`endif
`endif

>>> rtl/dsb_pkg.sv
// ----------------------------------------------------------------------------
// dsb_pkg
// Shared constants and types of the dual bump evaluator.
// ----------------------------------------------------------------------------
`default_nettype none
package dsb_pkg;
  localparam int TIME_WIDTH_DEF  = 32;
  localparam int LEVEL_WIDTH_DEF = 16;

  localparam int U_BITS         = 16;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = U_BITS / BITS_PER_STAGE;
  // entry, divider, square, cubic, scale, round, output
  localparam int EDGE_LAT       = DIV_STAGES + 6;

  localparam int CFG_DATA_WIDTH  = 64;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int OUT_WIDTH       = 16;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_B0_RISE   = 3'd0,
    REG_B0_FALL   = 3'd1,
    REG_B0_LEVELS = 3'd2,
    REG_B1_RISE   = 3'd3,
    REG_B1_FALL   = 3'd4,
    REG_B1_LEVELS = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    SEL_INTERP = 2'd0,
    SEL_A      = 2'd1,
    SEL_B      = 2'd2
  } edge_sel_t;
endpackage
`default_nettype wire

>>> rtl/dual_smooth_bump_eval.sv
// ----------------------------------------------------------------------------
// dual_smooth_bump_eval
// Two smoothstep bump functions evaluated per time sample, saturated Q4.12.
// ----------------------------------------------------------------------------
// Most of the pipeline is the 8-stage, 2-bit-per-stage divider chain.
// Throughput: one request per cycle unless stalled; every stage is a plain
// register stage. The whole pipeline holds while a result waits at output.
// Reset (rst, synchronous) clears all settings to zero and empties the pipe.
`default_nettype none
`include "dual_smooth_bump_eval_assert.svh"
module dual_smooth_bump_eval #(
  parameter int TIME_WIDTH  = dsb_pkg::TIME_WIDTH_DEF,
  parameter int LEVEL_WIDTH = dsb_pkg::LEVEL_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [dsb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [dsb_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [31:0]                         time_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [dsb_pkg::OUT_WIDTH-1:0]     bump0_value,
  output logic signed [dsb_pkg::OUT_WIDTH-1:0]     bump1_value
);
  localparam int TW  = TIME_WIDTH;
  localparam int LW  = LEVEL_WIDTH;
  localparam int EW  = LW + 3;
  localparam int SW  = (LW + 4 > dsb_pkg::OUT_WIDTH) ? LW + 4 : dsb_pkg::OUT_WIDTH;
  localparam int LAT = dsb_pkg::EDGE_LAT;
  localparam longint MAXV = (longint'(1) <<< (LW - 1)) - 1;
  localparam logic signed [SW-1:0] SAT_MAX = SW'(MAXV);
  localparam logic signed [SW-1:0] SAT_MIN = SW'(-MAXV - 1);

  logic [63:0] rise_times [0:1];
  logic [63:0] fall_times [0:1];
  logic [31:0] levels     [0:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        rise_times[i] <= '0;
        fall_times[i] <= '0;
        levels[i]     <= '0;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        dsb_pkg::REG_B0_RISE:   rise_times[0] <= cfg_data;
        dsb_pkg::REG_B0_FALL:   fall_times[0] <= cfg_data;
        dsb_pkg::REG_B0_LEVELS: levels[0]     <= cfg_data[31:0];
        dsb_pkg::REG_B1_RISE:   rise_times[1] <= cfg_data;
        dsb_pkg::REG_B1_FALL:   fall_times[1] <= cfg_data;
        dsb_pkg::REG_B1_LEVELS: levels[1]     <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic         en;
  logic [LAT:0] vchain;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vchain[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vchain <= '0;
    end else if (en) begin
      vchain <= {vchain[LAT-1:0], in_valid};
    end
  end

  logic signed [SW-1:0] sat [0:1];

  for (genvar j = 0; j < 2; j++) begin : g_bump
    logic [63:0]           lv_ext;
    logic signed [LW:0]    base, peak, dfall;
    logic signed [EW-1:0]  rise_v, fall_v;
    logic signed [SW-1:0]  sum_c;

    assign lv_ext = {32'd0, levels[j]};
    assign base   = (LW+1)'($signed(lv_ext[LW-1:0]));
    assign peak   = (LW+1)'($signed(lv_ext[2*LW-1:LW]));
    assign dfall  = base - peak;

    dsb_edge #(.TIME_WIDTH(TW), .LEVEL_WIDTH(LW)) u_rise (
      .clk     (clk),
      .en      (en),
      .t       (time_value[TW-1:0]),
      .t_start (rise_times[j][TW-1:0]),
      .t_end   (rise_times[j][32+TW-1:32]),
      .lv_a    (base),
      .lv_b    (peak),
      .value   (rise_v)
    );

    dsb_edge #(.TIME_WIDTH(TW), .LEVEL_WIDTH(LW)) u_fall (
      .clk     (clk),
      .en      (en),
      .t       (time_value[TW-1:0]),
      .t_start (fall_times[j][TW-1:0]),
      .t_end   (fall_times[j][32+TW-1:32]),
      .lv_a    ('0),
      .lv_b    (dfall),
      .value   (fall_v)
    );

    assign sum_c = SW'(rise_v) + SW'(fall_v);

    always_ff @(posedge clk) begin
      if (en) begin
        priority if (sum_c > SAT_MAX) begin
          sat[j] <= SAT_MAX;
        end else if (sum_c < SAT_MIN) begin
          sat[j] <= SAT_MIN;
        end else begin
          sat[j] <= sum_c;
        end
      end
    end
  end

  assign bump0_value = sat[0][dsb_pkg::OUT_WIDTH-1:0];
  assign bump1_value = sat[1][dsb_pkg::OUT_WIDTH-1:0];

  `DSB_ASSERT_RST(a_reset_empty, vchain == '0)
  `DSB_ASSERT_NEXT(a_empty_no_out, en && vchain[LAT-1:0] == '0 && !in_valid, !out_valid)
  `DSB_ASSERT_NEXT(a_stall_holds, !en, $stable(vchain))
  `DSB_ASSERT_IMPL(a_ready_on_free, !out_valid, in_ready)
endmodule
`default_nettype wire

>>> rtl/dsb_edge.sv
// ----------------------------------------------------------------------------
// dsb_edge
// Pipelined smoothstep edge: level a before start, b from end, cubic between.
// ----------------------------------------------------------------------------
`default_nettype none
module dsb_edge #(
  parameter int TIME_WIDTH  = dsb_pkg::TIME_WIDTH_DEF,
  parameter int LEVEL_WIDTH = dsb_pkg::LEVEL_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [TIME_WIDTH-1:0]         t,
  input  wire logic [TIME_WIDTH-1:0]         t_start,
  input  wire logic [TIME_WIDTH-1:0]         t_end,
  input  wire logic signed [LEVEL_WIDTH:0]   lv_a,
  input  wire logic signed [LEVEL_WIDTH:0]   lv_b,
  output logic signed [LEVEL_WIDTH+2:0]      value
);
  localparam int TW = TIME_WIDTH;
  localparam int UB = dsb_pkg::U_BITS;
  localparam int NS = dsb_pkg::DIV_STAGES;
  localparam int BS = dsb_pkg::BITS_PER_STAGE;
  localparam int DW = LEVEL_WIDTH + 2;   // delta width, signed
  localparam int MW = DW - 1;            // magnitude width
  localparam int EW = LEVEL_WIDTH + 3;   // edge value width
  localparam int SEL_LAST = NS + 4;      // round stage index

  dsb_pkg::edge_sel_t sel_pipe [0:SEL_LAST];
  dsb_pkg::edge_sel_t sel_in;

  logic [TW-1:0] rem_q [0:NS];
  logic [TW-1:0] den_q [0:NS];
  logic [UB-1:0] quo_q [0:NS];

  always_comb begin
    priority if (t >= t_end) begin
      sel_in = dsb_pkg::SEL_B;
    end else if (t < t_start) begin
      sel_in = dsb_pkg::SEL_A;
    end else begin
      sel_in = dsb_pkg::SEL_INTERP;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_pipe[0] <= sel_in;
      rem_q[0]    <= t - t_start;
      den_q[0]    <= t_end - t_start;
      quo_q[0]    <= '0;
      for (int i = 1; i <= SEL_LAST; i++) begin
        sel_pipe[i] <= sel_pipe[i-1];
      end
    end
  end

  // restoring division, remainder below the divisor for samples inside the edge
  for (genvar k = 0; k < NS; k++) begin : g_div
    logic [TW-1:0] rem_next;
    logic [UB-1:0] quo_next;
    always_comb begin
      logic [TW:0] sh;
      rem_next = rem_q[k];
      quo_next = quo_q[k];
      for (int b = 0; b < BS; b++) begin
        sh = {rem_next, 1'b0};
        if (sh >= {1'b0, den_q[k]}) begin
          sh       = sh - {1'b0, den_q[k]};
          quo_next = {quo_next[UB-2:0], 1'b1};
        end else begin
          quo_next = {quo_next[UB-2:0], 1'b0};
        end
        rem_next = sh[TW-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1] <= rem_next;
        den_q[k+1] <= den_q[k];
        quo_q[k+1] <= quo_next;
      end
    end
  end

  logic [UB-1:0]     u_s;
  logic [2*UB-1:0]   u2_s;
  logic [UB+1:0]     w_c;
  logic [2*UB+UB+1:0] hp_c;
  logic [32:0]       h_s;
  logic signed [DW-1:0] delta_c;
  logic [MW-1:0]     mag_s;
  logic              neg_s, neg_p;
  logic [MW+16:0]    pa_s;
  logic [MW+15:0]    pb_s;
  logic [MW+17:0]    rs_c;
  logic signed [MW:0] sr_s;

  assign w_c     = (UB+2)'(3 * 65536) - {1'b0, u_s, 1'b0};
  assign hp_c    = u2_s * w_c + (3*UB+2)'(32768);
  assign delta_c = DW'(lv_b) - DW'(lv_a);
  assign rs_c    = (MW+18)'(pa_s) + (MW+18)'(32768) + (MW+18)'(pb_s[MW+15:16]);

  always_ff @(posedge clk) begin
    if (en) begin
      u_s   <= quo_q[NS];
      u2_s  <= quo_q[NS] * quo_q[NS];
      h_s   <= hp_c[48:16];
      neg_s <= delta_c < 0;
      mag_s <= delta_c < 0 ? MW'(-delta_c) : MW'(delta_c);
      pa_s  <= mag_s * h_s[32:16];
      pb_s  <= mag_s * h_s[15:0];
      neg_p <= neg_s;
      sr_s  <= neg_p ? -$signed({1'b0, rs_c[MW+15:16]}) : $signed({1'b0, rs_c[MW+15:16]});
      unique case (sel_pipe[SEL_LAST])
        dsb_pkg::SEL_A:  value <= EW'(lv_a);
        dsb_pkg::SEL_B:  value <= EW'(lv_b);
        default:         value <= EW'(lv_a) + EW'(sr_s);
      endcase
    end
  end
endmodule
`default_nettype wire
